/* hdl/rta_pkg.sv */
// shared types and constants for the route table with aging
package rta_pkg;

    localparam int ENTRIES     = 32;
    localparam int INTERFACES  = 16;
    localparam int SLOT_W      = $clog2(ENTRIES);
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int ADDR_W      = 64;
    localparam int IF_W        = 4;
    localparam int TIME_W      = 32;
    localparam int RETRY_W     = 9;
    localparam int PI_W        = 16;
    localparam int MR_W        = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

    typedef enum logic [1:0] {
        CMD_LEARN  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        EV_LOOKUP    = 3'd0,
        EV_REFRESHED = 3'd1,
        EV_ADDED     = 3'd2,
        EV_MOVED     = 3'd3,
        EV_EXPIRED   = 3'd4,
        EV_PROBE     = 3'd5,
        EV_FULL      = 3'd6,
        EV_TICK_DONE = 3'd7
    } t_event;

    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES    = 1'd1;

    // what the datapath shall do this cycle
    typedef struct packed {
        logic               load;      // capture the request
        logic               read;      // read slot at scan index
        logic               scan_clr;  // scan index to zero
        logic               scan_inc;
        logic               refresh;   // restamp matched slot, clear retries
        logic               remove;    // clear valid of matched slot
        logic               add;       // write free slot
        logic               tick_upd;  // apply tick outcome to scanned slot
        logic               emit;      // load output register
        t_event             ev;
        logic               use_match; // payload from matched slot
        logic               use_slot;  // payload from scanned slot
        logic               last;
    } t_cmd_bus;

    // what the datapath reports back
    typedef struct packed {
        t_cmd               cmd;
        logic               match;
        logic               same_if;
        logic               has_free;
        logic               scan_end;  // index at last slot
        logic               slot_valid;
        logic               slot_aged;
        logic               slot_expire;
        logic               out_busy;
    } t_status;

endpackage

/* hdl/rta_datapath.sv */
// datapath: entry store, match logic, tick scan and output register
module rta_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rta_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rta_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]                   i_command,
    input  logic [63:0]                  i_address_high,
    input  logic [63:0]                  i_address_low,
    input  logic [3:0]                   i_interface_id,
    input  logic [31:0]                  i_current_time,
    input  rta_pkg::t_cmd_bus            i_ctl,
    output rta_pkg::t_status             o_sts,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_event_res,
    output logic [63:0]                  o_address_high_res,
    output logic [63:0]                  o_address_low_res,
    output logic [3:0]                   o_interface_id_res,
    output logic                         o_hit,
    output logic [8:0]                   o_retry_count,
    output logic                         o_last
);
    import rta_pkg::*;

    logic [PI_W-1:0]   r_pi;
    logic [MR_W-1:0]   r_mr;
    t_cmd              r_cmd;
    logic [ADDR_W-1:0] r_ah, r_al;
    logic [IF_W-1:0]   r_if;
    logic [TIME_W-1:0] r_now;

    logic [ENTRIES-1:0] r_vld;
    logic [ADDR_W-1:0]  r_eah [ENTRIES];
    logic [ADDR_W-1:0]  r_eal [ENTRIES];
    logic [IF_W-1:0]    r_eif [ENTRIES];
    logic [TIME_W-1:0]  r_est [ENTRIES];
    logic [RETRY_W-1:0] r_ert [ENTRIES];

    logic [SLOT_W-1:0]  r_scan;
    // registered match result
    logic               r_match;
    logic [SLOT_W-1:0]  r_mslot;
    logic               r_hasfree;
    logic [SLOT_W-1:0]  r_fslot;
    // registered slot read for tick
    logic [ADDR_W-1:0]  r_sah, r_sal;
    logic [IF_W-1:0]    r_sif;
    logic [TIME_W-1:0]  r_sst;
    logic [RETRY_W-1:0] r_srt;
    logic               r_svld;

    logic               r_ov;
    t_event             r_oev;
    logic [ADDR_W-1:0]  r_oah, r_oal;
    logic [IF_W-1:0]    r_oif;
    logic               r_ohit, r_olast;
    logic [RETRY_W-1:0] r_ort;

    logic [ADDR_W-1:0]  key_ah, key_al;
    logic [ENTRIES-1:0] hit_vec;
    logic               n_match, n_hasfree;
    logic [SLOT_W-1:0]  n_mslot, n_fslot;
    logic [ENTRIES-1:0] vld_after;
    logic [RETRY_W-1:0] inc_rt;
    logic [TIME_W-1:0]  age;

    // match the incoming address while it is being taken
    assign key_ah = i_ctl.load ? i_address_high : r_ah;
    assign key_al = i_ctl.load ? i_address_low  : r_al;

    always_comb begin
        for (int k = 0; k < ENTRIES; k++) begin
            hit_vec[k] = r_vld[k] && r_eah[k] == key_ah && r_eal[k] == key_al;
        end
    end

    // priority encode matches and free slots
    always_comb begin
        n_match = 1'b0;
        n_mslot = '0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (hit_vec[k]) begin
                n_match = 1'b1;
                n_mslot = SLOT_W'(k);
            end
        end
    end

    always_comb begin
        vld_after = r_vld;
        if (i_ctl.remove) begin
            vld_after[r_mslot] = 1'b0;
        end
        n_hasfree = 1'b0;
        n_fslot   = '0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (!vld_after[k]) begin
                n_hasfree = 1'b1;
                n_fslot   = SLOT_W'(k);
            end
        end
    end

    assign inc_rt = (r_srt < RETRY_MAX) ? r_srt + 1'b1 : r_srt;
    assign age    = r_now - r_sst;

    always_comb begin
        o_sts.cmd         = r_cmd;
        o_sts.match       = r_match;
        o_sts.same_if     = r_eif[r_mslot] == r_if;
        o_sts.has_free    = r_hasfree;
        o_sts.scan_end    = r_scan == SLOT_W'(ENTRIES - 1);
        o_sts.slot_valid  = r_svld;
        o_sts.slot_aged   = age >= TIME_W'(r_pi);
        o_sts.slot_expire = inc_rt > RETRY_W'(r_mr);
        o_sts.out_busy    = r_ov && i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pi  <= PI_W'(60);
            r_mr  <= MR_W'(3);
            r_vld <= '0;
            r_ov  <= 1'b0;
            r_cmd <= CMD_NONE;
            r_scan <= '0;
            r_svld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PROBE_INTERVAL: r_pi <= i_cfg_data;
                    CFG_MAX_RETRIES:    r_mr <= i_cfg_data[MR_W-1:0];
                    default: ;
                endcase
            end
            if (i_ctl.load) begin
                r_cmd <= t_cmd'(i_command);
            end
            if (i_ctl.scan_clr) begin
                r_scan <= '0;
            end else if (i_ctl.scan_inc) begin
                r_scan <= r_scan + 1'b1;
            end
            if (i_ctl.read) begin
                r_svld <= r_vld[r_scan];
            end
            if (i_ctl.remove) begin
                r_vld[r_mslot] <= 1'b0;
            end
            if (i_ctl.add) begin
                r_vld[r_fslot] <= 1'b1;
            end
            if (i_ctl.tick_upd && o_sts.slot_expire) begin
                r_vld[r_scan] <= 1'b0;
            end
            if (i_ctl.emit) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ah  <= i_address_high;
            r_al  <= i_address_low;
            r_if  <= i_interface_id;
            r_now <= i_current_time;
        end
        r_match   <= n_match;
        r_mslot   <= n_mslot;
        r_hasfree <= n_hasfree;
        r_fslot   <= n_fslot;
        if (i_ctl.read) begin
            r_sah <= r_eah[r_scan];
            r_sal <= r_eal[r_scan];
            r_sif <= r_eif[r_scan];
            r_sst <= r_est[r_scan];
            r_srt <= r_ert[r_scan];
        end
        if (i_ctl.refresh) begin
            r_est[r_mslot] <= r_now;
            r_ert[r_mslot] <= '0;
        end
        if (i_ctl.add) begin
            r_eah[r_fslot] <= r_ah;
            r_eal[r_fslot] <= r_al;
            r_eif[r_fslot] <= r_if;
            r_est[r_fslot] <= r_now;
            r_ert[r_fslot] <= '0;
        end
        if (i_ctl.tick_upd) begin
            r_ert[r_scan] <= inc_rt;
            if (!o_sts.slot_expire) begin
                r_est[r_scan] <= r_now;
            end
        end
        if (i_ctl.emit) begin
            r_oev   <= i_ctl.ev;
            r_olast <= i_ctl.last;
            r_ohit  <= 1'b0;
            if (i_ctl.use_slot) begin
                r_oah <= r_sah;
                r_oal <= r_sal;
                r_oif <= r_sif;
                r_ort <= inc_rt;
            end else if (i_ctl.use_match) begin
                r_oah  <= r_ah;
                r_oal  <= r_al;
                r_oif  <= r_eif[r_mslot];
                r_ort  <= r_ert[r_mslot];
                r_ohit <= i_ctl.ev == EV_LOOKUP;
            end else if (i_ctl.ev == EV_TICK_DONE) begin
                r_oah <= '0;
                r_oal <= '0;
                r_oif <= '0;
                r_ort <= '0;
            end else begin
                r_oah <= r_ah;
                r_oal <= r_al;
                r_oif <= (i_ctl.ev == EV_LOOKUP) ? '0 : r_if;
                r_ort <= '0;
            end
        end
    end

    assign o_valid            = r_ov;
    assign o_event_res        = r_oev;
    assign o_address_high_res = r_oah;
    assign o_address_low_res  = r_oal;
    assign o_interface_id_res = r_oif;
    assign o_hit              = r_ohit;
    assign o_retry_count      = r_ort;
    assign o_last             = r_olast;

    a_no_emit_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.emit |-> !(r_ov && i_stall))
        else $error("result overwritten while stalled");
    a_add_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.add |=> r_vld[$past(r_fslot)])
        else $error("added slot not valid");
    a_hit_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ohit) |-> r_oev == EV_LOOKUP)
        else $error("hit on non-lookup result");

endmodule

/* hdl/rta_ctrl.sv */
// controller state machine sequencing learn, lookup and tick scan
module rta_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  rta_pkg::t_status  i_sts,
    output rta_pkg::t_cmd_bus o_ctl
);
    import rta_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MATCH = 7'b0000010,
        ST_ADD   = 7'b0000100,
        ST_READ  = 7'b0001000,
        ST_EVAL  = 7'b0010000,
        ST_DONE  = 7'b0100000,
        ST_WAIT  = 7'b1000000
    } t_state;

    t_state r_st, n_st;

    assign o_stall = r_st != ST_IDLE;

    always_comb begin
        n_st  = r_st;
        o_ctl = '0;
        o_ctl.ev = EV_LOOKUP;
        unique case (r_st)
            ST_IDLE: begin
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_st = ST_MATCH;
                end
            end
            ST_MATCH: begin
                // match result registered, act on it
                if (!i_sts.out_busy) begin
                    priority case (i_sts.cmd)
                        CMD_LOOKUP: begin
                            o_ctl.emit = 1'b1;
                            o_ctl.ev = EV_LOOKUP;
                            o_ctl.use_match = i_sts.match;
                            o_ctl.last = 1'b1;
                            n_st = ST_IDLE;
                        end
                        CMD_LEARN: begin
                            if (i_sts.match && i_sts.same_if) begin
                                o_ctl.refresh = 1'b1;
                                o_ctl.emit = 1'b1;
                                o_ctl.ev = EV_REFRESHED;
                                o_ctl.last = 1'b1;
                                n_st = ST_IDLE;
                            end else if (i_sts.match) begin
                                o_ctl.remove = 1'b1;
                                o_ctl.emit = 1'b1;
                                o_ctl.ev = EV_MOVED;
                                o_ctl.use_match = 1'b1;
                                n_st = ST_WAIT;
                            end else begin
                                n_st = ST_ADD;
                            end
                        end
                        CMD_TICK: begin
                            o_ctl.scan_clr = 1'b1;
                            n_st = ST_READ;
                        end
                        default: n_st = ST_IDLE;
                    endcase
                end
            end
            ST_WAIT: begin
                // free slot search settles after removal
                n_st = ST_ADD;
            end
            ST_ADD: begin
                if (!i_sts.out_busy) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.last = 1'b1;
                    o_ctl.add = i_sts.has_free;
                    o_ctl.ev = i_sts.has_free ? EV_ADDED : EV_FULL;
                    n_st = ST_IDLE;
                end
            end
            ST_READ: begin
                o_ctl.read = 1'b1;
                n_st = ST_EVAL;
            end
            ST_EVAL: begin
                if (!(i_sts.slot_valid && i_sts.slot_aged)) begin
                    o_ctl.scan_inc = 1'b1;
                    n_st = i_sts.scan_end ? ST_DONE : ST_READ;
                end else if (!i_sts.out_busy) begin
                    o_ctl.tick_upd = 1'b1;
                    o_ctl.emit = 1'b1;
                    o_ctl.use_slot = 1'b1;
                    o_ctl.ev = i_sts.slot_expire ? EV_EXPIRED : EV_PROBE;
                    o_ctl.scan_inc = 1'b1;
                    n_st = i_sts.scan_end ? ST_DONE : ST_READ;
                end
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.ev = EV_TICK_DONE;
                    o_ctl.last = 1'b1;
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st))
        else $error("state not one-hot");
    a_accept_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |-> r_st == ST_IDLE)
        else $error("request taken while busy");
    a_add_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.add |=> r_st == ST_IDLE)
        else $error("add not final");

endmodule

/* hdl/route_table_with_aging.sv */
// top level of the route table with aging
//  channel  | direction | handshake       | payload
//  request  | in        | i_valid/o_stall | command, address, interface, time
//  result   | out       | o_valid/i_stall | event, address, interface, hit, retries, last
//  config   | in        | i_cfg_we        | i_cfg_idx, i_cfg_data
// learn and lookup: a request cycle, then a registered match over all slots
// tick scans each slot with a registered read, then an evaluate step
// synchronous active-low reset clears valid bits, state and config to defaults
// a stalled result holds the controller; the next request waits for the prior one
module route_table_with_aging (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rta_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rta_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_command,
    input  logic [63:0]                    i_address_high,
    input  logic [63:0]                    i_address_low,
    input  logic [3:0]                     i_interface_id,
    input  logic [31:0]                    i_current_time,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [2:0]                     o_event_res,
    output logic [63:0]                    o_address_high_res,
    output logic [63:0]                    o_address_low_res,
    output logic [3:0]                     o_interface_id_res,
    output logic                           o_hit,
    output logic [8:0]                     o_retry_count,
    output logic                           o_last
);
    import rta_pkg::*;

    t_cmd_bus ctl;
    t_status  sts;

    rta_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    rta_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_command          (i_command),
        .i_address_high     (i_address_high),
        .i_address_low      (i_address_low),
        .i_interface_id     (i_interface_id),
        .i_current_time     (i_current_time),
        .i_ctl              (ctl),
        .o_sts              (sts),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_event_res        (o_event_res),
        .o_address_high_res (o_address_high_res),
        .o_address_low_res  (o_address_low_res),
        .o_interface_id_res (o_interface_id_res),
        .o_hit              (o_hit),
        .o_retry_count      (o_retry_count),
        .o_last             (o_last)
    );

endmodule

/* sim/route_table_with_aging_test.sv */
// self-checking testbench for the route table with aging
module route_table_with_aging_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rta_pkg::*;

    typedef struct packed {
        t_cmd        cmd;
        logic [63:0] ah;
        logic [63:0] al;
        logic [3:0]  itf;
        logic [31:0] now;
    } t_req;

    typedef struct packed {
        t_event      ev;
        logic [63:0] ah;
        logic [63:0] al;
        logic [3:0]  itf;
        logic        hit;
        logic [8:0]  retries;
        logic        last;
    } t_route_ev;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [1:0]            i_command = '0;
    logic [63:0]           i_address_high = '0;
    logic [63:0]           i_address_low = '0;
    logic [3:0]            i_interface_id = '0;
    logic [31:0]           i_current_time = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [2:0]            o_event_res;
    logic [63:0]           o_address_high_res;
    logic [63:0]           o_address_low_res;
    logic [3:0]            o_interface_id_res;
    logic                  o_hit;
    logic [8:0]            o_retry_count;
    logic                  o_last;

    route_table_with_aging DUT (.*);

    t_req        pending_reqs[$];
    t_route_ev   expected_events[$];
    t_req        cur_req;
    int          mismatches = 0;
    int          send_idle = 0;
    int          recv_stall = 0;
    logic        hold_start = 1'b0;
    int          hold_cnt = 0;

    // predictor state
    logic [15:0] pr_interval = 16'd60;
    logic [7:0]  pr_max_retries = 8'd3;
    logic        tb_valid[ENTRIES];
    logic [63:0] tb_ah[ENTRIES];
    logic [63:0] tb_al[ENTRIES];
    logic [3:0]  tb_if[ENTRIES];
    logic [31:0] tb_stamp[ENTRIES];
    logic [8:0]  tb_retries[ENTRIES];

    logic [63:0] addr_pool[40];
    logic [31:0] now_t;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    function automatic void push_ev(t_event ev, logic [63:0] ah, logic [63:0] al,
                                    logic [3:0] itf, logic hit, logic [8:0] rc, logic last);
        t_route_ev e;
        e.ev = ev; e.ah = ah; e.al = al; e.itf = itf;
        e.hit = hit; e.retries = rc; e.last = last;
        expected_events = {expected_events, e};
    endfunction

    function automatic int find_route(logic [63:0] ah, logic [63:0] al);
        for (int i = 0; i < ENTRIES; i++)
            if (tb_valid[i] && tb_ah[i] == ah && tb_al[i] == al) return i;
        return -1;
    endfunction

    function automatic void predict_route(t_req r);
        int s;
        logic [31:0] age;
        case (r.cmd)
            CMD_LEARN: begin
                s = find_route(r.ah, r.al);
                if (s >= 0 && tb_if[s] == r.itf) begin
                    tb_stamp[s] = r.now;
                    tb_retries[s] = '0;
                    push_ev(EV_REFRESHED, r.ah, r.al, r.itf, 1'b0, '0, 1'b1);
                    return;
                end
                if (s >= 0) begin
                    push_ev(EV_MOVED, r.ah, r.al, tb_if[s], 1'b0, tb_retries[s], 1'b0);
                    tb_valid[s] = 1'b0;
                end
                s = -1;
                for (int i = ENTRIES - 1; i >= 0; i--)
                    if (!tb_valid[i]) s = i;
                if (s < 0) begin
                    push_ev(EV_FULL, r.ah, r.al, r.itf, 1'b0, '0, 1'b1);
                end else begin
                    tb_valid[s] = 1'b1;
                    tb_ah[s] = r.ah;
                    tb_al[s] = r.al;
                    tb_if[s] = r.itf;
                    tb_stamp[s] = r.now;
                    tb_retries[s] = '0;
                    push_ev(EV_ADDED, r.ah, r.al, r.itf, 1'b0, '0, 1'b1);
                end
            end
            CMD_LOOKUP: begin
                s = find_route(r.ah, r.al);
                if (s >= 0) push_ev(EV_LOOKUP, r.ah, r.al, tb_if[s], 1'b1, tb_retries[s], 1'b1);
                else push_ev(EV_LOOKUP, r.ah, r.al, '0, 1'b0, '0, 1'b1);
            end
            CMD_TICK: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!tb_valid[i]) continue;
                    age = r.now - tb_stamp[i];
                    if (age < {16'd0, pr_interval}) continue;
                    if (tb_retries[i] != RETRY_MAX) tb_retries[i] = tb_retries[i] + 1'b1;
                    if (tb_retries[i] > {1'b0, pr_max_retries}) begin
                        tb_valid[i] = 1'b0;
                        push_ev(EV_EXPIRED, tb_ah[i], tb_al[i], tb_if[i], 1'b0,
                                tb_retries[i], 1'b0);
                    end else begin
                        tb_stamp[i] = r.now;
                        push_ev(EV_PROBE, tb_ah[i], tb_al[i], tb_if[i], 1'b0,
                                tb_retries[i], 1'b0);
                    end
                end
                push_ev(EV_TICK_DONE, '0, '0, '0, 1'b0, '0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) predict_route(cur_req);
            if (!i_valid || !o_stall) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    r = pending_reqs.pop_front();
                    cur_req = r;
                    i_valid <= 1'b1;
                    i_command <= r.cmd;
                    i_address_high <= r.ah;
                    i_address_low <= r.al;
                    i_interface_id <= r.itf;
                    i_current_time <= r.now;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
        else if (hold_start) hold_cnt <= 300;
    end

    // result monitor
    always @(posedge i_clk) begin
        t_route_ev exp_ev;
        t_route_ev got;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got.ev = t_event'(o_event_res);
                got.ah = o_address_high_res;
                got.al = o_address_low_res;
                got.itf = o_interface_id_res;
                got.hit = o_hit;
                got.retries = o_retry_count;
                got.last = o_last;
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: ev %0d addr %h_%h if %0d", got.ev,
                                 got.ah, got.al, got.itf);
                end else begin
                    exp_ev = expected_events.pop_front();
                    if (got != exp_ev) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp ev %0d %h_%h if %0d hit %0d rc %0d last %0d",
                                      " / got ev %0d %h_%h if %0d hit %0d rc %0d last %0d"},
                                     exp_ev.ev, exp_ev.ah, exp_ev.al, exp_ev.itf, exp_ev.hit,
                                     exp_ev.retries, exp_ev.last, got.ev, got.ah, got.al,
                                     got.itf, got.hit, got.retries, got.last);
                    end
                end
            end
            i_stall <= (hold_cnt != 0) || ($urandom_range(0, 99) < recv_stall);
        end
    end

    task automatic add_req(t_cmd cmd, logic [63:0] ah, logic [63:0] al, logic [3:0] itf,
                           logic [31:0] t);
        t_req r;
        r.cmd = cmd; r.ah = ah; r.al = al; r.itf = itf; r.now = t;
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PROBE_INTERVAL) pr_interval = data;
        else pr_max_retries = data[7:0];
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || i_valid || expected_events.size() != 0)
            @(posedge i_clk);
        repeat (2 * ENTRIES + 16) @(posedge i_clk);
    endtask

    task automatic random_reqs(int n, int step);
        int k;
        int pick;
        logic [3:0] itf;
        for (int j = 0; j < n; j++) begin
            k = $urandom_range(0, 39);
            itf = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
            now_t = now_t + $urandom_range(0, step);
            pick = $urandom_range(0, 99);
            if (pick < 45) add_req(CMD_LEARN, addr_pool[k], ~addr_pool[k], itf, now_t);
            else if (pick < 70) add_req(CMD_LOOKUP, addr_pool[k], ~addr_pool[k], itf, now_t);
            else if (pick < 95) add_req(CMD_TICK, {$urandom, $urandom}, {$urandom, $urandom},
                                        itf, now_t);
            else add_req(CMD_NONE, addr_pool[k], {$urandom, $urandom}, itf, now_t);
        end
    endtask

    initial begin
        foreach (tb_valid[i]) tb_valid[i] = 1'b0;
        foreach (addr_pool[i]) addr_pool[i] = {$urandom, $urandom};
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings
        add_req(CMD_LEARN, '0, '0, 4'd0, 32'd0);
        add_req(CMD_LEARN, '1, '1, 4'd15, 32'd0);
        add_req(CMD_LOOKUP, '0, '0, 4'd7, 32'd0);
        add_req(CMD_LOOKUP, 64'h1, '0, 4'd0, 32'd0);
        add_req(CMD_LEARN, '0, '0, 4'd0, 32'd10);
        add_req(CMD_LEARN, '1, '1, 4'd3, 32'd10);
        add_req(CMD_NONE, '1, '1, 4'd15, '1);
        add_req(CMD_TICK, '0, '0, 4'd0, 32'd59);
        add_req(CMD_TICK, '0, '0, 4'd0, 32'd70);
        add_req(CMD_TICK, '0, '0, 4'd0, 32'd130);
        add_req(CMD_LOOKUP, '1, '1, 4'd0, 32'd0);
        add_req(CMD_TICK, '0, '0, 4'd0, 32'd190);
        add_req(CMD_TICK, '0, '0, 4'd0, 32'd250);
        add_req(CMD_LEARN, 64'h5, 64'h6, 4'd9, 32'hFFFF_FFFF);
        add_req(CMD_LEARN, '1, '0, 4'd15, 32'd5);
        add_req(CMD_TICK, '0, '0, 4'd0, 32'd100);
        now_t = 32'd300;
        random_reqs(25, 20);
        wait_idle();

        // interval of one, immediate expiry, long hold-off on the receiver
        write_cfg(CFG_PROBE_INTERVAL, 16'd1);
        write_cfg(CFG_MAX_RETRIES, 16'd0);
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        random_reqs(45, 2);
        wait_idle();

        // longest interval and retries: the table fills up
        send_idle = 73;
        write_cfg(CFG_PROBE_INTERVAL, 16'hFFFF);
        write_cfg(CFG_MAX_RETRIES, 16'd255);
        now_t = 32'hFFFF_FF00;
        random_reqs(45, 8);
        wait_idle();

        // zero interval
        send_idle = 0;
        recv_stall = 73;
        write_cfg(CFG_PROBE_INTERVAL, 16'd0);
        write_cfg(CFG_MAX_RETRIES, 16'd2);
        random_reqs(45, 3);
        wait_idle();

        send_idle = 22;
        recv_stall = 22;
        write_cfg(CFG_PROBE_INTERVAL, 16'd6);
        write_cfg(CFG_MAX_RETRIES, 16'd3);
        random_reqs(50, 4);
        wait_idle();

        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
